>>> rtl/core/sha1sh_pkg.sv
// constants and types shared by the sha-1 stream hasher
package sha1sh_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned NumChain = 5;
    localparam int unsigned Rounds   = 80;

    localparam word_t InitWord0 = 32'h67452301;
    localparam word_t InitWord1 = 32'hEFCDAB89;
    localparam word_t InitWord2 = 32'h98BADCFE;
    localparam word_t InitWord3 = 32'h10325476;
    localparam word_t InitWord4 = 32'hC3D2E1F0;

    localparam word_t RoundK0 = 32'h5A827999;
    localparam word_t RoundK1 = 32'h6ED9EBA1;
    localparam word_t RoundK2 = 32'h8F1BBCDC;
    localparam word_t RoundK3 = 32'hCA62C1D6;

    localparam logic [7:0] PadMark = 8'h80;

    localparam logic CmdAbsorb = 1'b0;
    localparam logic CmdFinish = 1'b1;

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        word_t r;
        r = (x << n) | (x >> (6'd32 - {1'b0, n}));
        return r;
    endfunction

endpackage

>>> rtl/core/sha1_stream_hasher.sv
// SHA-1 stream hasher: one byte per request is buffered; a finish request pads the
// message, runs the final compressions and returns the five digest words, most
// significant first. The byte that completes a 64-byte block holds the input off while
// 80 rounds run through the single round adder and then the chaining add is made. A
// finish pads with 64 - fill bytes and compresses each padded block (one extra block of
// padding when 56 or more bytes are buffered), then the five words are offered one per
// cycle as the output side takes them. Input is not accepted from the start of a
// compression or finish until it is done. After the length count wraps past 2^64 bits
// further bytes are dropped and the digest words come out as zero with length_error set.
module sha1_stream_hasher
    import sha1sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        length_error,
    output logic        last
);

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StPad   = 3'd1;
    localparam logic [2:0] StRound = 3'd2;
    localparam logic [2:0] StFinal = 3'd3;
    localparam logic [2:0] StEmit  = 3'd4;

    // control
    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic        ovf_reg, ovf_next;
    logic        finishing_reg, finishing_next;
    logic        len_blk_reg, len_blk_next;
    logic        pad_first_reg, pad_first_next;
    logic        err_reg, err_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    word_t       h_reg [NumChain];
    word_t       h_next [NumChain];

    // datapath
    logic [511:0] win_reg, win_next;
    word_t        a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t        a_next, b_next, c_next, d_next, e_next;

    logic         in_fire, out_fire;
    logic         shift_byte;
    logic [7:0]   byte_in;
    logic [63:0]  len_shift;
    logic [63:0]  len_sum;
    word_t        f_val, k_val, t_val, w_cur, w_new;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready  = (state_reg == StIdle);
    assign out_valid = (state_reg == StEmit);

    assign digest_word  = err_reg ? 32'd0 : h_reg[idx_reg];
    assign word_index   = idx_reg;
    assign length_error = err_reg;
    assign last         = (idx_reg == 3'(NumChain - 1));

    // round function and constant by round group
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = RoundK0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = RoundK1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = RoundK2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = RoundK3;
        end
    end

    // window word j sits at [511-32j -: 32]; taps at words 0, 2, 8, 13
    assign w_cur = win_reg[511:480];
    assign w_new = rotl(win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416] ^ w_cur, 5'd1);
    assign t_val = rotl(a_reg, 5'd5) + f_val + e_reg + w_cur + k_val;

    // length bytes go out big-endian while the fill runs from 56 to 63
    assign len_shift = bit_len_reg << {fill_reg[2:0], 3'b000};
    assign len_sum   = bit_len_reg + 64'd8;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bit_len_next   = bit_len_reg;
        ovf_next       = ovf_reg;
        finishing_next = finishing_reg;
        len_blk_next   = len_blk_reg;
        pad_first_next = pad_first_reg;
        err_next       = err_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        h_next         = h_reg;
        shift_byte     = 1'b0;
        byte_in        = data_byte;

        unique case (state_reg)
            StIdle:
            begin
                if (in_fire)
                begin
                    if (cmd == CmdFinish)
                    begin
                        finishing_next = 1'b1;
                        err_next       = ovf_reg;
                        pad_first_next = 1'b1;
                        len_blk_next   = (fill_reg < 6'd56);
                        state_next     = StPad;
                    end
                    else if (!ovf_reg)
                    begin
                        shift_byte   = 1'b1;
                        fill_next    = fill_reg + 6'd1;
                        bit_len_next = len_sum;
                        if (len_sum == 64'd0)
                        begin
                            ovf_next = 1'b1;
                        end
                        if (fill_reg == 6'd63)
                        begin
                            round_next = 7'd0;
                            state_next = StRound;
                        end
                    end
                end
            end
            StPad:
            begin
                shift_byte     = 1'b1;
                pad_first_next = 1'b0;
                fill_next      = fill_reg + 6'd1;
                if (pad_first_reg)
                begin
                    byte_in = PadMark;
                end
                else if (len_blk_reg && fill_reg >= 6'd56)
                begin
                    byte_in = len_shift[63:56];
                end
                else
                begin
                    byte_in = 8'd0;
                end
                if (fill_reg == 6'd63)
                begin
                    round_next = 7'd0;
                    state_next = StRound;
                end
            end
            StRound:
            begin
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(Rounds - 1))
                begin
                    state_next = StFinal;
                end
            end
            StFinal:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                if (!finishing_reg)
                begin
                    state_next = StIdle;
                end
                else if (len_blk_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = StEmit;
                end
                else
                begin
                    // second padding block carries the length
                    len_blk_next = 1'b1;
                    state_next   = StPad;
                end
            end
            StEmit:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(NumChain - 1))
                    begin
                        h_next[0]      = InitWord0;
                        h_next[1]      = InitWord1;
                        h_next[2]      = InitWord2;
                        h_next[3]      = InitWord3;
                        h_next[4]      = InitWord4;
                        fill_next      = 6'd0;
                        bit_len_next   = 64'd0;
                        ovf_next       = 1'b0;
                        finishing_next = 1'b0;
                        err_next       = 1'b0;
                        idx_next       = 3'd0;
                        state_next     = StIdle;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_comb
    begin
        win_next = win_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        e_next   = e_reg;
        if (shift_byte)
        begin
            win_next = {win_reg[503:0], byte_in};
            if (fill_reg == 6'd63)
            begin
                a_next = h_reg[0];
                b_next = h_reg[1];
                c_next = h_reg[2];
                d_next = h_reg[3];
                e_next = h_reg[4];
            end
        end
        else if (state_reg == StRound)
        begin
            win_next = {win_reg[479:0], w_new};
            a_next   = t_val;
            b_next   = a_reg;
            c_next   = rotl(b_reg, 5'd30);
            d_next   = c_reg;
            e_next   = d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            fill_reg      <= 6'd0;
            bit_len_reg   <= 64'd0;
            ovf_reg       <= 1'b0;
            finishing_reg <= 1'b0;
            len_blk_reg   <= 1'b0;
            pad_first_reg <= 1'b0;
            err_reg       <= 1'b0;
            round_reg     <= 7'd0;
            idx_reg       <= 3'd0;
            h_reg[0]      <= InitWord0;
            h_reg[1]      <= InitWord1;
            h_reg[2]      <= InitWord2;
            h_reg[3]      <= InitWord3;
            h_reg[4]      <= InitWord4;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_len_reg   <= bit_len_next;
            ovf_reg       <= ovf_next;
            finishing_reg <= finishing_next;
            len_blk_reg   <= len_blk_next;
            pad_first_reg <= pad_first_next;
            err_reg       <= err_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

endmodule
